/* rtl/calclk_pkg.sv */
// Shared types and constants for the calendar clock with alarm.
package calclk_pkg;

  localparam logic [11:0] FirstYear = 12'd1984;
  localparam logic [11:0] LastYear  = 12'd2099;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned EventW   = 7;

  localparam logic [CfgIdxW-1:0] CfgAlarmHour   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAlarmMinute = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAlarmEnable = 2'd2;

  localparam int unsigned EvSecond = 0;
  localparam int unsigned EvMinute = 1;
  localparam int unsigned EvHour   = 2;
  localparam int unsigned EvDay    = 3;
  localparam int unsigned EvMonth  = 4;
  localparam int unsigned EvYear   = 5;
  localparam int unsigned EvAlarm  = 6;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_SET_TIME = 2'd1,
    MODE_SET_DATE = 2'd2
  } mode_e;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  wday;
  } cal_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] min;
    logic       en;
  } alarm_t;

endpackage

/* rtl/calclk_next.sv */
// Next calendar state and event flags for one tick or set request.
module calclk_next (
  input  calclk_pkg::cal_t           cal_i,
  input  calclk_pkg::alarm_t         alarm_i,
  input  logic [1:0]                 mode_i,
  input  logic [5:0]                 new_second_i,
  input  logic [5:0]                 new_minute_i,
  input  logic [4:0]                 new_hour_i,
  input  logic [4:0]                 new_day_i,
  input  logic [3:0]                 new_month_i,
  input  logic [11:0]                new_year_i,
  output calclk_pkg::cal_t           cal_o,
  output logic [calclk_pkg::EventW-1:0] events_o
);

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_off(input logic [3:0] m);
    logic [2:0] off;
    case (m)
      4'd2, 4'd3, 4'd11: off = 3'd3;
      4'd4, 4'd7:        off = 3'd6;
      4'd5:              off = 3'd1;
      4'd6:              off = 3'd4;
      4'd8:              off = 3'd2;
      4'd9, 4'd12:       off = 3'd5;
      default:           off = 3'd0;
    endcase
    return off;
  endfunction

  // 8 is 1 modulo 7: fold octal digits, then a final subtract
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [4:0] s;
    logic [3:0] t;
    logic [3:0] r;
    s = {3'b0, x[7:6]} + {2'b0, x[5:3]} + {2'b0, x[2:0]};
    t = {2'b0, s[4:3]} + {1'b0, s[2:0]};
    r = (t >= 4'd7) ? t - 4'd7 : t;
    return r[2:0];
  endfunction

  logic [3:0]  m_c;
  logic [11:0] y_c;
  logic        leap_c;
  logic [4:0]  len_c;
  logic [4:0]  d_c;
  logic [11:0] span_full;
  logic [6:0]  span;
  logic [7:0]  w0;
  logic [7:0]  w1;
  logic [7:0]  w2;
  logic [4:0]  len_cur;
  calclk_pkg::cal_t           nxt;
  logic [calclk_pkg::EventW-1:0] ev;

  // clamp the requested date and work out its weekday
  always_comb begin
    if (new_month_i == 4'd0) begin
      m_c = 4'd1;
    end else if (new_month_i > 4'd12) begin
      m_c = 4'd12;
    end else begin
      m_c = new_month_i;
    end
    if (new_year_i < calclk_pkg::FirstYear) begin
      y_c = calclk_pkg::FirstYear;
    end else if (new_year_i > calclk_pkg::LastYear) begin
      y_c = calclk_pkg::LastYear;
    end else begin
      y_c = new_year_i;
    end
    leap_c = (y_c[1:0] == 2'd0);
    len_c  = month_len(m_c, leap_c);
    if (new_day_i == 5'd0) begin
      d_c = 5'd1;
    end else if (new_day_i > len_c) begin
      d_c = len_c;
    end else begin
      d_c = new_day_i;
    end
    span_full = y_c - calclk_pkg::FirstYear;
    span      = span_full[6:0];
    w0        = {1'b0, span} + {3'b0, span[6:2]};
    w1        = (leap_c && (m_c < 4'd3)) ? w0 - 8'd1 : w0;
    w2        = w1 + {3'b0, d_c} + {5'b0, month_off(m_c)};
  end

  assign len_cur = month_len(cal_i.month, cal_i.year[1:0] == 2'd0);

  always_comb begin
    nxt = cal_i;
    ev  = '0;
    case (calclk_pkg::mode_e'(mode_i))
      calclk_pkg::MODE_TICK: begin
        ev[calclk_pkg::EvSecond] = 1'b1;
        if (cal_i.sec >= 6'd59) begin
          nxt.sec = 6'd0;
          ev[calclk_pkg::EvMinute] = 1'b1;
          if (cal_i.min >= 6'd59) begin
            nxt.min = 6'd0;
            ev[calclk_pkg::EvHour] = 1'b1;
            if (cal_i.hour >= 5'd23) begin
              nxt.hour = 5'd0;
              ev[calclk_pkg::EvDay] = 1'b1;
              nxt.wday = (cal_i.wday >= 3'd6) ? 3'd0 : cal_i.wday + 3'd1;
              if (cal_i.day >= len_cur) begin
                nxt.day = 5'd1;
                ev[calclk_pkg::EvMonth] = 1'b1;
                if (cal_i.month >= 4'd12) begin
                  nxt.month = 4'd1;
                  ev[calclk_pkg::EvYear] = 1'b1;
                  nxt.year = (cal_i.year >= calclk_pkg::LastYear) ?
                             calclk_pkg::FirstYear : cal_i.year + 12'd1;
                end else begin
                  nxt.month = cal_i.month + 4'd1;
                end
              end else begin
                nxt.day = cal_i.day + 5'd1;
              end
            end else begin
              nxt.hour = cal_i.hour + 5'd1;
            end
          end else begin
            nxt.min = cal_i.min + 6'd1;
          end
          ev[calclk_pkg::EvAlarm] = alarm_i.en && (nxt.hour == alarm_i.hour) &&
                                    (nxt.min == alarm_i.min);
        end else begin
          nxt.sec = cal_i.sec + 6'd1;
        end
      end
      calclk_pkg::MODE_SET_TIME: begin
        nxt.sec  = (new_second_i > 6'd59) ? 6'd59 : new_second_i;
        nxt.min  = (new_minute_i > 6'd59) ? 6'd59 : new_minute_i;
        nxt.hour = (new_hour_i > 5'd23) ? 5'd23 : new_hour_i;
      end
      calclk_pkg::MODE_SET_DATE: begin
        nxt.day   = d_c;
        nxt.month = m_c;
        nxt.year  = y_c;
        nxt.wday  = mod7(w2);
      end
      default: begin
      end
    endcase
  end

  assign cal_o    = nxt;
  assign events_o = ev;

endmodule

/* rtl/calendar_clock_with_alarm.sv */
// Top level of the calendar clock with alarm.
//
//  channel  signals                               direction
//  -------  ------------------------------------  ---------
//  in       in_valid_i / in_stall_o, mode, new_*  request in
//  out      out_valid_o / out_stall_i, *_now, ev  result out
//  cfg      cfg_valid_i / cfg_ready_o, index/data write in
//
// Result path: input register, then the calendar update into the state and
// result registers. One request per cycle while the output is not stalled.
// The calendar registers act as the result register; the carry chain
// through second to year sets the path length.
// Reset gives 00:00:59 on 1 January 1984, Sunday, alarm off.
// A stalled result holds the input register, which then stalls the input.
module calendar_clock_with_alarm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [5:0]                          new_second_i,
  input  logic [5:0]                          new_minute_i,
  input  logic [4:0]                          new_hour_i,
  input  logic [4:0]                          new_day_i,
  input  logic [3:0]                          new_month_i,
  input  logic [11:0]                         new_year_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [5:0]                          second_now_o,
  output logic [5:0]                          minute_now_o,
  output logic [4:0]                          hour_now_o,
  output logic [4:0]                          day_now_o,
  output logic [3:0]                          month_now_o,
  output logic [11:0]                         year_now_o,
  output logic [2:0]                          weekday_now_o,
  output logic [calclk_pkg::EventW-1:0]       events_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [calclk_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [calclk_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic        in_vld_q, in_vld_d;
  logic [1:0]  mode_q;
  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [4:0]  hour_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [11:0] year_q;
  logic        out_vld_q, out_vld_d;
  logic        accept;
  logic        advance;

  calclk_pkg::cal_t   cal_q, cal_d;
  calclk_pkg::alarm_t alarm_q;
  logic [calclk_pkg::EventW-1:0] events_q, events_d;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q && out_stall_i;
    if (advance) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      sec_q   <= new_second_i;
      min_q   <= new_minute_i;
      hour_q  <= new_hour_i;
      day_q   <= new_day_i;
      month_q <= new_month_i;
      year_q  <= new_year_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        calclk_pkg::CfgAlarmHour:   alarm_q.hour <= cfg_data_i[4:0];
        calclk_pkg::CfgAlarmMinute: alarm_q.min  <= cfg_data_i;
        calclk_pkg::CfgAlarmEnable: alarm_q.en   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  calclk_next u_next (
    .cal_i        (cal_q),
    .alarm_i      (alarm_q),
    .mode_i       (mode_q),
    .new_second_i (sec_q),
    .new_minute_i (min_q),
    .new_hour_i   (hour_q),
    .new_day_i    (day_q),
    .new_month_i  (month_q),
    .new_year_i   (year_q),
    .cal_o        (cal_d),
    .events_o     (events_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '{sec: 6'd59, min: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd1,
                 year: calclk_pkg::FirstYear, wday: 3'd0};
    end else if (advance) begin
      cal_q <= cal_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      events_q <= events_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign second_now_o  = cal_q.sec;
  assign minute_now_o  = cal_q.min;
  assign hour_now_o    = cal_q.hour;
  assign day_now_o     = cal_q.day;
  assign month_now_o   = cal_q.month;
  assign year_now_o    = cal_q.year;
  assign weekday_now_o = cal_q.wday;
  assign events_o      = events_q;

endmodule

/* rtl/calclk_checker.sv */
// Port-level assertions for the calendar clock with alarm, bound to the top level.
module calclk_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [5:0]                      second_now_o,
  input logic [5:0]                      minute_now_o,
  input logic [4:0]                      hour_now_o,
  input logic [3:0]                      month_now_o,
  input logic [4:0]                      day_now_o,
  input logic [calclk_pkg::EventW-1:0]   events_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(events_o) &&
    $stable(second_now_o))
    else $error("stalled result changed");

  a_minute_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && events_o[calclk_pkg::EvMinute] |->
    second_now_o == 6'd0 && events_o[calclk_pkg::EvSecond])
    else $error("minute event without second rollover");

  a_day_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && events_o[calclk_pkg::EvDay] |->
    hour_now_o == 5'd0 && minute_now_o == 6'd0 && events_o[calclk_pkg::EvHour])
    else $error("day event without midnight");

  a_year_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && events_o[calclk_pkg::EvYear] |->
    month_now_o == 4'd1 && day_now_o == 5'd1 && events_o[calclk_pkg::EvMonth])
    else $error("year event without new year's day");

  a_alarm_minute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && events_o[calclk_pkg::EvAlarm] |->
    events_o[calclk_pkg::EvMinute])
    else $error("alarm outside a minute rollover");

endmodule

bind calendar_clock_with_alarm calclk_checker u_calclk_checker (.*);
